// ===== rtl/lpft_pkg.sv =====
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared constants for the LRU page frame table.
// ----------------------------------------------------------------------------
package lpft_pkg;

  localparam int FRAMES_DEF     = 8;   // frames in the table
  localparam int PAGE_BITS_DEF  = 16;  // page number width
  localparam int FRAMES_RST     = 8;   // frames_in_use after reset
  localparam int CFG_MIN_W      = 4;   // minimum frames_in_use register width
  localparam int FAULT_W        = 32;  // fault counter width

endpackage

// ===== rtl/lru_page_frame_table.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_table
// Fully associative page frame table with true LRU replacement.
// ----------------------------------------------------------------------------
// Takes one page reference per cycle and returns one result item for each,
// passing through the input register, then the result register. All
// tags are compared in parallel and ranks are aged in the same cycle, so the
// flop-based frame table is read and updated once per item and a new item
// may follow every cycle; the only stall is back-pressure on the result
// side. A hit makes the frame most recent. A miss fills the lowest empty
// frame in use, or else replaces the oldest one (lowest index on a tie).
// The fault count saturates. tlast on an input item clears valid bits,
// ranks and the fault count after that item is handled. frames_in_use
// (0 acts as 1, above FRAMES acts as FRAMES) is to be written through the
// cfg channel only while the block is idle; the block does not enforce it.
module lru_page_frame_table
  import lpft_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int SLOT_W   = $clog2(FRAMES),
  localparam int CFG_W    = (FRAMES >= 16) ? $clog2(FRAMES + 1) : CFG_MIN_W,
  localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8,
  localparam int RES_W    = 2 + SLOT_W + PAGE_BITS + FAULT_W,
  localparam int OUT_W    = ((RES_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration: frames_in_use
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  // input items
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // page
  input  logic             in_tlast,   // last_ref
  // result items
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // hit, frame_slot, evicted_valid,
                                       // evicted_page, fault_count
);

  localparam int RANK_W = SLOT_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
  localparam logic [RANK_W:0]   RANK_NEW = (RANK_W + 1)'(FRAMES);

  // configuration
  logic [CFG_W-1:0] frames_in_use_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_W'(FRAMES_RST);
    end else if (cfg_valid) begin
      frames_in_use_r <= cfg_data;
    end
  end

  // input register
  logic                 in_v_r;
  logic [PAGE_BITS-1:0] in_page_r;
  logic                 in_last_r;
  logic                 advance;
  logic                 out_v_r;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_page_r <= in_tdata[PAGE_BITS-1:0];
      in_last_r <= in_tlast;
    end
  end

  // frame table state
  logic [PAGE_BITS-1:0] frame_tag_r  [FRAMES];
  logic [FRAMES-1:0]    frame_valid_r;
  logic [RANK_W-1:0]    rank_r       [FRAMES];
  logic [FAULT_W-1:0]   fault_r;

  // lookup
  logic [CFG_W-1:0]     n_act;
  logic [FRAMES-1:0]    active, match, empty, victim;
  logic [FRAMES-1:0]    hit_oh, empty_oh, slot_oh;
  logic                 hit_c, empty_any;
  logic [SLOT_W-1:0]    slot_c;
  logic [PAGE_BITS-1:0] ev_page_c;
  logic [RANK_W-1:0]    slot_rank;
  logic [RANK_W:0]      old_rank;
  logic [FAULT_W-1:0]   fault_c;

  always_comb begin
    if (frames_in_use_r == '0) begin
      n_act = CFG_W'(1);
    end else if (frames_in_use_r > CFG_W'(FRAMES)) begin
      n_act = CFG_W'(FRAMES);
    end else begin
      n_act = frames_in_use_r;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = CFG_W'(i) < n_act;
      match[i]  = active[i] && frame_valid_r[i] && (frame_tag_r[i] == in_page_r);
      empty[i]  = active[i] && !frame_valid_r[i];
    end
  end

  // first-of-the-oldest: no earlier frame as old, no later frame older
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      victim[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (active[j] && (((j < i) && (rank_r[j] >= rank_r[i])) ||
                          ((j > i) && (rank_r[j] > rank_r[i])))) begin
          victim[i] = 1'b0;
        end
      end
    end
  end

  assign hit_oh    = match & (~match + FRAMES'(1));
  assign empty_oh  = empty & (~empty + FRAMES'(1));
  assign hit_c     = |match;
  assign empty_any = |empty;
  assign slot_oh   = hit_c ? hit_oh : (empty_any ? empty_oh : victim);

  always_comb begin
    slot_c    = '0;
    ev_page_c = '0;
    slot_rank = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (slot_oh[i]) begin
        slot_c    = slot_c | SLOT_W'(i);
        slot_rank = slot_rank | rank_r[i];
      end
      if (victim[i]) begin
        ev_page_c = ev_page_c | frame_tag_r[i];
      end
    end
  end

  logic ev_valid_c;
  assign ev_valid_c = !hit_c && !empty_any;
  assign old_rank   = (!hit_c && empty_any) ? RANK_NEW : {1'b0, slot_rank};
  assign fault_c    = (!hit_c && (fault_r != '1)) ? fault_r + FAULT_W'(1) : fault_r;

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fault_r       <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (advance) begin
      if (in_last_r) begin
        frame_valid_r <= '0;
        fault_r       <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= '0;
        end
      end else begin
        frame_valid_r <= frame_valid_r | slot_oh;
        fault_r       <= fault_c;
        for (int i = 0; i < FRAMES; i++) begin
          if (slot_oh[i]) begin
            rank_r[i] <= '0;
          end else if (active[i] && frame_valid_r[i] &&
                       ({1'b0, rank_r[i]} < old_rank) && (rank_r[i] < RANK_MAX)) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !hit_c) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (slot_oh[i]) begin
          frame_tag_r[i] <= in_page_r;
        end
      end
    end
  end

  // result register
  logic [RES_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= {fault_c, (ev_valid_c ? ev_page_c : PAGE_BITS'(0)), ev_valid_c,
                slot_c, hit_c};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(res_r);

  // checks
  a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !hit_c && !in_last_r && (fault_r != '1)
      |=> fault_r == $past(fault_r) + FAULT_W'(1))
    else $error("fault count did not step on a miss");

  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |=> (frame_valid_r == '0) && (fault_r == '0))
    else $error("table not cleared after last item");

  a_valid_grow: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_last_r
      |=> $countones(frame_valid_r) >= $past($countones(frame_valid_r)))
    else $error("frame lost its valid bit without a clear");

endmodule

// ===== bench/tb_lru_page_frame_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_frame_table
// Self-checking bench for the LRU page frame table.
// ----------------------------------------------------------------------------
// Page references go in on the input stream and each one is predicted
// against a local copy of the frame table: tags, valid bits, age ranks,
// fault count and frames_in_use. Results are popped in order and compared
// field by field. Directed cases cover fill, hit, eviction, clear on tlast
// and the clamped frames_in_use values. Random reference strings then run
// over small working sets so hits and evictions both occur. Idle gaps and
// result back-pressure are random.
// ----------------------------------------------------------------------------
module tb_lru_page_frame_table;
  import lpft_pkg::*;

  localparam int NUM_FRAMES  = FRAMES_DEF;
  localparam int PG_W        = PAGE_BITS_DEF;
  localparam int SLOT_W      = $clog2(NUM_FRAMES);
  localparam int CFG_W       = CFG_MIN_W;
  localparam int IN_W        = ((PG_W + 7) / 8) * 8;
  localparam int RES_W       = 2 + SLOT_W + PG_W + FAULT_W;
  localparam int OUT_W       = ((RES_W + 7) / 8) * 8;
  localparam int RANDOM_REFS = 1800;
  localparam int LIMIT       = 1_000_000;
  localparam int TAIL_CYCLES = 6;

  typedef struct {
    bit                hit;
    bit [SLOT_W-1:0]   slot;
    bit                ev_valid;
    bit [PG_W-1:0]     ev_page;
    bit [FAULT_W-1:0]  faults;
  } ref_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // page
  logic             in_tlast;   // last_ref
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // hit, frame_slot, evicted_valid, evicted_page,
                                // fault_count

  // local copy of the frame table
  bit [PG_W-1:0]    frame_page [NUM_FRAMES];
  bit               resident   [NUM_FRAMES];
  int               frame_age  [NUM_FRAMES];
  bit [FAULT_W-1:0] fault_total;
  bit [CFG_W-1:0]   frames_cfg;

  ref_result_t pending_results[$];

  int errors;
  int cycle_count;
  int refs_sent;
  int results_seen;
  int hits_predicted;
  int evictions_predicted;
  int strings_done;
  int cfg_writes;
  bit idle_on;
  bit stall_on;

  lru_page_frame_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------- predictor
  // Frame f becomes most recent; younger valid frames age by one, saturating.
  function automatic void touch_frame(int f, int n, int old_age);
    for (int g = 0; g < n; g++) begin
      if (g != f && resident[g] && frame_age[g] < old_age &&
          frame_age[g] < NUM_FRAMES - 1)
        frame_age[g]++;
    end
    frame_age[f] = 0;
    resident[f]  = 1'b1;
  endfunction

  function automatic ref_result_t lookup_page(bit [PG_W-1:0] pg, bit last_ref);
    ref_result_t r;
    int n;
    int slot;
    int best;
    bit found;
    bit empty;
    r = '{default: 0};
    if (frames_cfg == 0) n = 1;
    else if (frames_cfg > NUM_FRAMES) n = NUM_FRAMES;
    else n = int'(frames_cfg);
    found = 1'b0;
    empty = 1'b0;
    slot  = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && resident[i] && frame_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      touch_frame(slot, n, frame_age[slot]);
      hits_predicted++;
    end else begin
      if (fault_total != '1) fault_total++;
      for (int i = 0; i < n; i++) begin
        if (!empty && !resident[i]) begin
          empty = 1'b1;
          slot  = i;
        end
      end
      if (empty) begin
        frame_page[slot] = pg;
        touch_frame(slot, n, NUM_FRAMES);
      end else begin
        // oldest frame in use, lowest index on a tie
        best = 0;
        for (int i = 1; i < n; i++)
          if (frame_age[i] > frame_age[best]) best = i;
        slot       = best;
        r.ev_valid = 1'b1;
        r.ev_page  = frame_page[slot];
        frame_page[slot] = pg;
        touch_frame(slot, n, frame_age[slot]);
        evictions_predicted++;
      end
    end
    r.hit    = found;
    r.slot   = SLOT_W'(slot);
    r.faults = fault_total;
    if (last_ref) begin
      resident    = '{default: 0};
      frame_age   = '{default: 0};
      fault_total = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    ref_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("result item 0x%0h arrived with nothing expected", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.hit)
          report_mismatch("hit", 64'(out_tdata[0]), 64'(want.hit));
        if (out_tdata[SLOT_W:1] !== want.slot)
          report_mismatch("frame_slot", 64'(out_tdata[SLOT_W:1]), 64'(want.slot));
        if (out_tdata[SLOT_W+1] !== want.ev_valid)
          report_mismatch("evicted_valid", 64'(out_tdata[SLOT_W+1]),
                          64'(want.ev_valid));
        if (out_tdata[SLOT_W+2 +: PG_W] !== want.ev_page)
          report_mismatch("evicted_page", 64'(out_tdata[SLOT_W+2 +: PG_W]),
                          64'(want.ev_page));
        if (out_tdata[SLOT_W+2+PG_W +: FAULT_W] !== want.faults)
          report_mismatch("fault_count", 64'(out_tdata[SLOT_W+2+PG_W +: FAULT_W]),
                          64'(want.faults));
      end
      results_seen++;
    end
  end

  // result side back-pressure
  initial begin : drive_out_ready
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 3) == 0) begin
        n = stall_len();
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Leaves tvalid high after the item is taken; release_and_drain lowers it.
  task automatic send_ref(bit [PG_W-1:0] pg, bit last_ref);
    int gap;
    gap = idle_on ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_W'(pg);
    in_tlast  = last_ref;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(lookup_page(pg, last_ref));
    refs_sent++;
  endtask

  task automatic release_and_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_frames(bit [CFG_W-1:0] value);
    release_and_drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    frames_cfg = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // Full table: fill, refresh, evict the oldest, clear on tlast.
  task automatic test_fill_and_evict();
    send_ref('0, 1'b0);
    send_ref('1, 1'b0);
    for (int p = 1; p <= 6; p++) send_ref(PG_W'(p), 1'b0);
    send_ref('0, 1'b0);          // refresh slot 0
    send_ref(16'h1234, 1'b0);    // evicts the all-ones page
    send_ref(16'haaaa, 1'b0);
    send_ref(16'h5555, 1'b1);    // clears afterwards
    send_ref(16'h5555, 1'b0);    // fault again after the clear
    release_and_drain();
  endtask

  // Clamped register values and frames dropped out of use.
  task automatic test_frame_limits();
    set_frames(4'd0);            // acts as one frame
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0008, 1'b0);
    send_ref(16'h0009, 1'b1);
    set_frames(4'hf);            // acts as the full table
    for (int p = 0; p < NUM_FRAMES; p++) send_ref(PG_W'(16'h10 + p), 1'b0);
    set_frames(4'd3);            // ranks of frames 0..2 now out of order
    send_ref(16'h0020, 1'b0);
    send_ref(16'h0021, 1'b0);
    send_ref(16'h0015, 1'b0);    // lives in frame 5, not in use: miss
    set_frames(4'd8);
    send_ref(16'h0015, 1'b1);    // frame 5 kept its page
  endtask

  task automatic test_random_strings();
    bit [PG_W-1:0] ws_pages[16];
    bit [CFG_W-1:0] cfg;
    int n_use;
    int ws;
    int len;
    int r;
    bit [PG_W-1:0] pg;
    bit last_ref;
    while (refs_sent < RANDOM_REFS + 40) begin
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) cfg = CFG_W'($urandom_range(9, 15));
        else if (r == 1) cfg = 4'd0;
        else cfg = CFG_W'($urandom_range(1, NUM_FRAMES));
        set_frames(cfg);
      end
      if (frames_cfg == 0) n_use = 1;
      else if (frames_cfg > NUM_FRAMES) n_use = NUM_FRAMES;
      else n_use = int'(frames_cfg);
      ws = n_use + $urandom_range(0, 4);
      for (int i = 0; i < ws; i++) ws_pages[i] = PG_W'($urandom);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                         : $urandom_range(1, 60);
      idle_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) pg = PG_W'($urandom);
        else pg = ws_pages[$urandom_range(0, ws - 1)];
        // most strings end with tlast, some run on into the next
        last_ref = (k == len - 1) ? ($urandom_range(0, 4) != 0)
                                  : ($urandom_range(0, 99) == 0);
        send_ref(pg, last_ref);
        // hold off until the result side is empty now and then
        if (k == len / 2 && $urandom_range(0, 5) == 0) release_and_drain();
      end
      strings_done++;
    end
    release_and_drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    errors     = 0;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    resident    = '{default: 0};
    frame_age   = '{default: 0};
    frame_page  = '{default: 0};
    fault_total = '0;
    frames_cfg  = CFG_W'(FRAMES_RST);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_fill_and_evict();
    test_frame_limits();
    test_random_strings();

    $display("covered %0d references in %0d strings, %0d register writes",
             refs_sent, strings_done, cfg_writes);
    $display("predicted %0d hits and %0d evictions, %0d results checked",
             hits_predicted, evictions_predicted, results_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
